@@ design/lkec_pkg.sv @@
// Shared types and codes for the keyed LRU entry cache.
// No dependencies; imported by lkec_cell and lru_keyed_entry_cache_unit.
package lkec_pkg;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_LOOKUP = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;

   localparam logic [2:0] STATUS_ADDED   = 3'd0;
   localparam logic [2:0] STATUS_MERGED  = 3'd1;
   localparam logic [2:0] STATUS_HIT     = 3'd2;
   localparam logic [2:0] STATUS_MISS    = 3'd3;
   localparam logic [2:0] STATUS_EXPIRED = 3'd4;
   localparam logic [2:0] STATUS_REMOVED = 3'd5;
   localparam logic [2:0] STATUS_RM_NONE = 3'd6;

   // update applied by every cell in the same cycle
   typedef enum logic [1:0] {
      CMD_NONE,
      CMD_PROMOTE,
      CMD_ADD,
      CMD_DROP
   } cmd_kind_type;

   // request fields broadcast to all cells
   typedef struct packed {
      logic [63:0] handle;
      logic [31:0] fs;
      logic [63:0] stamp;
      logic [63:0] attr;
      logic [63:0] now;
   } req_data_type;

endpackage

@@ design/lkec_cell.sv @@
// One cache slot: key, stamp, attribute, valid bit and recency rank.
// Forwards the registered scan record to its neighbor. Uses lkec_pkg.
module lkec_cell
   import lkec_pkg::*;
#(
   parameter int ENTRIES  = 16,
   parameter int CELL_IDX = 0
) (
   input  logic                          clock,
   input  logic                          reset,
   input  req_data_type                  req_data,
   input  logic [4*$clog2(ENTRIES)+131:0] scan_in,
   output logic [4*$clog2(ENTRIES)+131:0] scan_out,
   input  logic [2*$clog2(ENTRIES)+2:0]   cmd_in
);

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] MY_IDX   = IDX_W'(CELL_IDX);
   localparam logic [IDX_W-1:0] RANK_MAX = IDX_W'(ENTRIES - 1);

   typedef struct packed {
      logic             go;
      logic             hit;
      logic             live;
      logic [IDX_W-1:0] hit_idx;
      logic [IDX_W-1:0] hit_rank;
      logic [63:0]      hit_stamp;
      logic [63:0]      hit_attr;
      logic             free;
      logic [IDX_W-1:0] free_idx;
      logic [IDX_W-1:0] lru_idx;
   } scan_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [IDX_W-1:0] slot;
      logic [IDX_W-1:0] rank;
      logic             merge;
   } cmd_type;

   scan_type         rec_in, scan_in_rec, scan_ff;
   cmd_type          cmd;
   logic             valid_ff, valid_in;
   logic [IDX_W-1:0] rank_ff, rank_in;
   logic [63:0]      handle_ff, handle_in;
   logic [31:0]      fs_ff, fs_in;
   logic [63:0]      stamp_ff, stamp_in;
   logic [63:0]      attr_ff, attr_in;
   logic             match;
   logic             mine;

   assign scan_in_rec = scan_type'(scan_in);
   assign cmd         = cmd_type'(cmd_in);
   assign scan_out    = scan_ff;

   assign match = valid_ff && (handle_ff == req_data.handle) && (fs_ff == req_data.fs);
   assign mine  = (cmd.slot == MY_IDX);

   always_comb begin
      rec_in = scan_in_rec;
      if (match && !scan_in_rec.hit) begin
         rec_in.hit       = 1'b1;
         rec_in.live      = stamp_ff > req_data.now;
         rec_in.hit_idx   = MY_IDX;
         rec_in.hit_rank  = rank_ff;
         rec_in.hit_stamp = stamp_ff;
         rec_in.hit_attr  = attr_ff;
      end
      if (!valid_ff && !scan_in_rec.free) begin
         rec_in.free     = 1'b1;
         rec_in.free_idx = MY_IDX;
      end
      if (valid_ff && (rank_ff == RANK_MAX)) begin
         rec_in.lru_idx = MY_IDX;
      end
   end

   always_comb begin
      valid_in  = valid_ff;
      rank_in   = rank_ff;
      handle_in = handle_ff;
      fs_in     = fs_ff;
      stamp_in  = stamp_ff;
      attr_in   = attr_ff;
      unique case (cmd.kind)
         CMD_PROMOTE: begin
            if (mine) begin
               rank_in = '0;
               if (cmd.merge && (req_data.stamp > stamp_ff)) begin
                  stamp_in = req_data.stamp;
                  attr_in  = req_data.attr;
               end
            end else if (valid_ff && (rank_ff < cmd.rank)) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         CMD_ADD: begin
            if (mine) begin
               valid_in  = 1'b1;
               rank_in   = '0;
               handle_in = req_data.handle;
               fs_in     = req_data.fs;
               stamp_in  = req_data.stamp;
               attr_in   = req_data.attr;
            end else if (valid_ff) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         CMD_DROP: begin
            if (mine) begin
               valid_in = 1'b0;
               rank_in  = '0;
            end else if (valid_ff && (rank_ff > cmd.rank)) begin
               rank_in = rank_ff - 1'b1;
            end
         end
         CMD_NONE: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         rank_ff  <= '0;
         scan_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         rank_ff  <= rank_in;
         scan_ff  <= rec_in;
      end
   end

   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
      fs_ff     <= fs_in;
      stamp_ff  <= stamp_in;
      attr_ff   <= attr_in;
   end

endmodule

@@ design/lru_keyed_entry_cache_unit.sv @@
// Top level of the keyed LRU entry cache: request/result handshakes, control
// and the row of lkec_cell slots. Uses lkec_pkg.
//
// A fully associative cache of ENTRIES slots keyed by handle and file-system
// id, ordered by recency. Each request gives exactly one result. One request is
// worked at a time: after acceptance a scan record walks the row of slot
// cells, one cell per cycle, collecting the matching slot, the lowest free slot
// and the least recently used slot; then one update changes all cells at once
// and loads the result register, waiting while an earlier result is stalled.
// The next request is accepted while a result still waits to be taken. No
// clearing pass is needed after reset.
module lru_keyed_entry_cache_unit
   import lkec_pkg::*;
#(
   parameter int ENTRIES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [63:0] req_key_handle,
   input  logic [31:0] req_key_fs,
   input  logic [63:0] req_entry_stamp,
   input  logic [63:0] req_entry_attr,
   input  logic [63:0] req_now_time,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [63:0] rsp_found_attr,
   output logic [63:0] rsp_found_stamp,
   output logic        rsp_evicted
);

   localparam int IDX_W = $clog2(ENTRIES);

   typedef struct packed {
      logic             go;
      logic             hit;
      logic             live;
      logic [IDX_W-1:0] hit_idx;
      logic [IDX_W-1:0] hit_rank;
      logic [63:0]      hit_stamp;
      logic [63:0]      hit_attr;
      logic             free;
      logic [IDX_W-1:0] free_idx;
      logic [IDX_W-1:0] lru_idx;
   } scan_type;

   typedef struct packed {
      cmd_kind_type     kind;
      logic [IDX_W-1:0] slot;
      logic [IDX_W-1:0] rank;
      logic             merge;
   } cmd_type;

   typedef enum logic [1:0] {
      IDLE,
      SCAN,
      COMMIT
   } state_type;

   state_type    state_ff;
   logic         start_ff;
   logic [1:0]   kind_ff;
   req_data_type req_ff;
   scan_type     rec_ff;
   scan_type     chain [ENTRIES+1];
   scan_type     chain_head;
   cmd_type      cmd_in, cmd_bcast;
   logic [2:0]   status_in;
   logic [63:0]  fattr_in, fstamp_in;
   logic         evict_in;
   logic         accept;
   logic         commit_fire;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_status_ff;
   logic [63:0] rsp_found_attr_ff;
   logic [63:0] rsp_found_stamp_ff;
   logic        rsp_evicted_ff;

   assign req_stall       = (state_ff != IDLE);
   assign accept          = req_valid && !req_stall;
   assign commit_fire     = (state_ff == COMMIT) && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_found_attr  = rsp_found_attr_ff;
   assign rsp_found_stamp = rsp_found_stamp_ff;
   assign rsp_evicted     = rsp_evicted_ff;

   always_comb begin
      chain_head    = '0;
      chain_head.go = start_ff;
   end
   assign chain[0] = chain_head;

   for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
      lkec_cell #(
         .ENTRIES  (ENTRIES),
         .CELL_IDX (g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .req_data (req_ff),
         .scan_in  (chain[g]),
         .scan_out (chain[g+1]),
         .cmd_in   (cmd_bcast)
      );
   end

   // decode the finished scan into one update and one result
   always_comb begin
      cmd_in       = '0;
      cmd_in.kind  = CMD_NONE;
      status_in    = STATUS_MISS;
      fattr_in     = '0;
      fstamp_in    = '0;
      evict_in     = 1'b0;
      unique case (kind_ff)
         REQ_INSERT: begin
            if (rec_ff.hit) begin
               cmd_in.kind  = CMD_PROMOTE;
               cmd_in.slot  = rec_ff.hit_idx;
               cmd_in.rank  = rec_ff.hit_rank;
               cmd_in.merge = 1'b1;
               status_in    = STATUS_MERGED;
            end else begin
               cmd_in.kind = CMD_ADD;
               cmd_in.slot = rec_ff.free ? rec_ff.free_idx : rec_ff.lru_idx;
               evict_in    = !rec_ff.free;
               status_in   = STATUS_ADDED;
            end
         end
         REQ_LOOKUP: begin
            if (!rec_ff.hit) begin
               status_in = STATUS_MISS;
            end else if (rec_ff.live) begin
               cmd_in.kind = CMD_PROMOTE;
               cmd_in.slot = rec_ff.hit_idx;
               cmd_in.rank = rec_ff.hit_rank;
               status_in   = STATUS_HIT;
               fattr_in    = rec_ff.hit_attr;
               fstamp_in   = rec_ff.hit_stamp;
            end else begin
               status_in = STATUS_EXPIRED;
            end
         end
         REQ_REMOVE: begin
            if (rec_ff.hit) begin
               cmd_in.kind = CMD_DROP;
               cmd_in.slot = rec_ff.hit_idx;
               cmd_in.rank = rec_ff.hit_rank;
               status_in   = STATUS_REMOVED;
               fattr_in    = rec_ff.hit_attr;
               fstamp_in   = rec_ff.hit_stamp;
            end else begin
               status_in = STATUS_RM_NONE;
            end
         end
         default: begin
            status_in = STATUS_MISS;
         end
      endcase
   end

   always_comb begin
      cmd_bcast = cmd_in;
      if (!commit_fire) begin
         cmd_bcast.kind = CMD_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= accept;
         if (commit_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  state_ff <= SCAN;
               end
            end
            SCAN: begin
               if (chain[ENTRIES].go) begin
                  state_ff <= COMMIT;
               end
            end
            COMMIT: begin
               if (commit_fire) begin
                  state_ff           <= IDLE;
                  rsp_status_ff      <= status_in;
                  rsp_found_attr_ff  <= fattr_in;
                  rsp_found_stamp_ff <= fstamp_in;
                  rsp_evicted_ff     <= evict_in;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff      <= req_type;
         req_ff.handle <= req_key_handle;
         req_ff.fs     <= req_key_fs;
         req_ff.stamp  <= req_entry_stamp;
         req_ff.attr   <= req_entry_attr;
         req_ff.now    <= req_now_time;
      end
      if (chain[ENTRIES].go) begin
         rec_ff <= chain[ENTRIES];
      end
   end

endmodule
